// File: design/agpwm_pkg.sv
// Shared types and constants for the audio gain, peak meter and waveform block.
// Used by the arithmetic unit, the bin memory, the top level and the checker.
package agpwm_pkg;

  localparam int DEF_BINS    = 1024;
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [14:0] GAIN_MAX   = 15'd19661;
  localparam logic [14:0] SAMPLE_MAX = 15'd32767;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_GAIN      = 2'd0,
    REG_CHANNELS  = 2'd1,
    REG_TRACK_LEN = 2'd2,
    REG_OUT_EN    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic mul_en;
    logic div_load;
    logic div_step;
  } arith_ctl_t;

endpackage

// File: design/audio_gain_peak_waveform_meter.sv
// Digital volume with peak meter and waveform sampler. One beat in gives one beat out.
// A frame is scaled by the shared multiplier and, when it is sampled into a bin, its bin
// index comes from the restoring divider that yields one bin-index bit per cycle
// through a 34-bit subtractor; a frame past the track length is clamped to the last
// bin without dividing. A bin clear sweeps every bin to zero, and after reset the bins
// are swept to zero before the first beat is taken; configuration writes are taken at
// any time.
// Depends on agpwm_pkg, agpwm_arith and agpwm_bin_mem.
module audio_gain_peak_waveform_meter #(
  parameter int WAVEFORM_BINS = agpwm_pkg::DEF_BINS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_first, sample_second, bin_index, new_position, zero pad
  input  logic [agpwm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [agpwm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_first, out_second, frame_peak, buffer_level, bin_value, zero pad
  output logic [agpwm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [agpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [agpwm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import agpwm_pkg::*;

  localparam int BIN_AW = $clog2(WAVEFORM_BINS);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_MUL1   = 9'b000000100,
    S_MUL2   = 9'b000001000,
    S_SCALE2 = 9'b000010000,
    S_DIVLD  = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_READ   = 9'b010000000,
    S_UPD    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    PH_WORK = 2'b01,
    PH_DONE = 2'b10
  } phase_t;

  function automatic logic [16:0] abs17(input logic [15:0] s);
    return s[15] ? (17'd0 - {1'b1, s}) : {1'b0, s};
  endfunction

  function automatic logic [14:0] round_clamp(input logic [PROD_W-1:0] p);
    logic [PROD_W-15:0] q;
    logic [13:0]        r;
    logic               up;
    logic [PROD_W-14:0] qr;
    q  = p[PROD_W-1:14];
    r  = p[13:0];
    up = (r > 14'h2000) || ((r == 14'h2000) && q[0]);
    qr = {1'b0, q} + (PROD_W-13)'(up);
    return (qr > (PROD_W-13)'(SAMPLE_MAX)) ? SAMPLE_MAX : qr[14:0];
  endfunction

  function automatic logic [15:0] signed_out(input logic neg, input logic [14:0] m);
    return neg ? (16'd0 - {1'b0, m}) : {1'b0, m};
  endfunction

  state_t      state;
  phase_t      phase;

  logic [14:0] gain;
  logic [1:0]  chan;
  logic [31:0] track_len;
  logic        out_en;

  cmd_t        cmd;
  logic [15:0] s_first;
  logic [15:0] s_second;
  logic        eob;
  logic [9:0]  bin_idx;
  logic [31:0] new_pos;

  logic [31:0] position;
  logic [14:0] running;
  logic [14:0] mag1;
  logic [14:0] mag2;
  logic        neg1;
  logic        neg2;
  logic [14:0] peak;
  logic [14:0] binv;
  logic [BIN_AW-1:0] bin_sel;
  logic [BIN_AW-1:0] cnt;
  logic        bin_clamp;
  logic        clr_reply;

  arith_ctl_t          actl;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;
  logic [BIN_AW-1:0]   quo;

  logic              mem_we;
  logic [BIN_AW-1:0] mem_waddr;
  logic [14:0]       mem_wdata;
  logic [BIN_AW-1:0] rd_addr;
  logic [14:0]       rdata;

  logic [14:0] g_sat;
  logic        stereo;
  logic [14:0] mag_now;
  logic [14:0] peak_now;
  logic [14:0] run_max;
  logic [14:0] level_out;
  logic        in_range;
  logic        out_free;

  agpwm_arith #(.QW(BIN_AW)) u_arith (
    .clk     (clk),
    .ctl     (actl),
    .a       (mul_a),
    .b       (mul_b),
    .divisor (track_len),
    .prod    (prod),
    .quo     (quo)
  );

  agpwm_bin_mem #(.DEPTH(WAVEFORM_BINS)) u_bins (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign g_sat     = (gain > GAIN_MAX) ? GAIN_MAX : gain;
  assign stereo    = chan[1];
  assign mag_now   = round_clamp(prod);
  assign peak_now  = (stereo && (mag_now > mag1)) ? mag_now : mag1;
  assign run_max   = (peak > running) ? peak : running;
  assign level_out = ((cmd == CMD_FRAME) && out_en && eob) ? run_max : 15'd0;
  assign in_range  = 32'(bin_idx) < 32'(WAVEFORM_BINS);
  assign out_free  = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && (phase == PH_WORK);

  always_comb begin
    if (cmd == CMD_READ) begin
      rd_addr = BIN_AW'(bin_idx);
    end else if (bin_clamp) begin
      rd_addr = BIN_AW'(WAVEFORM_BINS - 1);
    end else begin
      rd_addr = quo;
    end
  end

  always_comb begin
    actl  = '0;
    mul_a = '0;
    mul_b = '0;
    if (phase == PH_WORK) begin
      case (state)
        S_MUL1: begin
          actl.mul_en = 1'b1;
          mul_a       = MUL_A_W'(abs17(s_first));
          mul_b       = MUL_B_W'(g_sat);
        end
        S_MUL2: begin
          actl.mul_en = 1'b1;
          mul_a       = MUL_A_W'(abs17(s_second));
          mul_b       = MUL_B_W'(g_sat);
        end
        S_SCALE2: begin
          actl.mul_en = 1'b1;
          mul_a       = position;
          mul_b       = MUL_B_W'(WAVEFORM_BINS);
        end
        S_DIVLD: begin
          actl.div_load = position < track_len;
        end
        S_DIV: begin
          actl.div_step = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bin_sel;
    mem_wdata = peak;
    if (phase == PH_WORK) begin
      if (state == S_CLEAR) begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = 15'd0;
      end else if ((state == S_UPD) && (cmd != CMD_READ) && (rdata < peak)) begin
        mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      phase         <= PH_WORK;
      cnt           <= '0;
      clr_reply     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      gain          <= 15'd16384;
      chan          <= 2'd2;
      track_len     <= 32'd0;
      out_en        <= 1'b0;
      position      <= 32'd0;
      running       <= 15'd0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN:      gain      <= cfg_data[14:0];
          REG_CHANNELS:  chan      <= cfg_data[1:0];
          REG_TRACK_LEN: track_len <= cfg_data[31:0];
          REG_OUT_EN:    out_en    <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (m_axis_tvalid && m_axis_tready && (phase != PH_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end

      if (phase == PH_DONE) begin
        if (out_free) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {3'd0, binv, level_out, peak,
                            signed_out(neg2, mag2), signed_out(neg1, mag1)};
          case (cmd)
            CMD_FRAME: begin
              if (out_en) begin
                position <= position + 32'd1;
                running  <= eob ? 15'd0 : run_max;
              end else if (eob) begin
                running <= 15'd0;
              end
            end
            CMD_SEEK: begin
              position <= new_pos;
              running  <= 15'd0;
            end
            default: begin
            end
          endcase
          phase <= PH_WORK;
          state <= S_IDLE;
        end
      end else begin
        case (state)
          S_CLEAR: begin
            if (cnt == BIN_AW'(WAVEFORM_BINS - 1)) begin
              cnt       <= '0;
              clr_reply <= 1'b0;
              if (clr_reply) begin
                phase <= PH_DONE;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              cnt <= cnt + BIN_AW'(1);
            end
          end
          S_IDLE: begin
            if (s_axis_tvalid) begin
              cmd      <= cmd_t'(s_axis_tuser);
              s_first  <= s_axis_tdata[15:0];
              s_second <= s_axis_tdata[31:16];
              bin_idx  <= s_axis_tdata[41:32];
              new_pos  <= s_axis_tdata[73:42];
              eob      <= s_axis_tlast;
              mag1     <= 15'd0;
              mag2     <= 15'd0;
              neg1     <= 1'b0;
              neg2     <= 1'b0;
              peak     <= 15'd0;
              binv     <= 15'd0;
              bin_clamp <= 1'b0;
              case (cmd_t'(s_axis_tuser))
                CMD_FRAME: begin
                  if (out_en) begin
                    state <= S_MUL1;
                  end else begin
                    phase <= PH_DONE;
                  end
                end
                CMD_READ:  state <= S_READ;
                CMD_SEEK:  phase <= PH_DONE;
                CMD_CLEAR: begin
                  state     <= S_CLEAR;
                  clr_reply <= 1'b1;
                end
                default:   phase <= PH_DONE;
              endcase
            end
          end
          S_MUL1: state <= S_MUL2;
          S_MUL2: begin
            mag1  <= mag_now;
            neg1  <= s_first[15];
            state <= S_SCALE2;
          end
          S_SCALE2: begin
            if (stereo) begin
              mag2 <= mag_now;
              neg2 <= s_second[15];
            end
            peak <= peak_now;
            if ((track_len != 32'd0) && (peak_now != 15'd0)) begin
              state <= S_DIVLD;
            end else begin
              phase <= PH_DONE;
            end
          end
          S_DIVLD: begin
            cnt <= '0;
            if (position >= track_len) begin
              bin_clamp <= 1'b1;
              state     <= S_READ;
            end else begin
              state <= S_DIV;
            end
          end
          S_DIV: begin
            if (cnt == BIN_AW'(BIN_AW - 1)) begin
              cnt   <= '0;
              state <= S_READ;
            end else begin
              cnt <= cnt + BIN_AW'(1);
            end
          end
          S_READ: begin
            bin_sel <= rd_addr;
            state   <= S_UPD;
          end
          S_UPD: begin
            if (cmd == CMD_READ) begin
              binv <= in_range ? rdata : 15'd0;
            end
            phase <= PH_DONE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// File: design/agpwm_arith.sv
// Shared arithmetic unit: registered 32x16 multiplier and a restoring divider
// that produces one quotient bit per cycle. Depends on agpwm_pkg.
module agpwm_arith #(
  parameter int QW = 10
) (
  input  logic                         clk,
  input  agpwm_pkg::arith_ctl_t        ctl,
  input  logic [agpwm_pkg::MUL_A_W-1:0] a,
  input  logic [agpwm_pkg::MUL_B_W-1:0] b,
  input  logic [31:0]                  divisor,
  output logic [agpwm_pkg::PROD_W-1:0] prod,
  output logic [QW-1:0]                quo
);
  import agpwm_pkg::*;

  logic [31:0]   rem;
  logic [QW-1:0] low_bits;
  logic [32:0]   trial;
  logic [33:0]   diff;
  logic          take;

  assign trial = {rem, low_bits[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};
  assign take  = ~diff[33];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
    if (ctl.div_load) begin
      rem      <= 32'(prod >> QW);
      low_bits <= prod[QW-1:0];
      quo      <= '0;
    end else if (ctl.div_step) begin
      rem      <= take ? diff[31:0] : trial[31:0];
      low_bits <= low_bits << 1;
      quo      <= {quo[QW-2:0], take};
    end
  end

endmodule

// File: design/agpwm_bin_mem.sv
// Waveform bin storage: one write port, one read port with registered data.
// Depends on agpwm_pkg for the default depth.
module agpwm_bin_mem #(
  parameter int DEPTH = agpwm_pkg::DEF_BINS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [14:0]              wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [14:0]              rdata
);
  logic [14:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/agpwm_checker.sv
// Port-level checks for the audio gain, peak meter and waveform block, bound to
// the top level. Depends on agpwm_pkg for port widths.
module agpwm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [agpwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import agpwm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  a_no_min_sample: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'h8000) && (m_axis_tdata[31:16] != 16'h8000))
    else $error("output sample not clamped");

  a_bin_read_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[76:62] != 15'd0) |-> (m_axis_tdata[61:0] == 62'd0))
    else $error("bin value mixed with frame fields");

  a_level_covers_peak: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[61:47] != 15'd0) |-> (m_axis_tdata[46:32] <= m_axis_tdata[61:47]))
    else $error("buffer level below frame peak");

endmodule

bind audio_gain_peak_waveform_meter agpwm_checker u_agpwm_checker (.*);
